### design/ets_pkg.sv
// Shared constants, codes and types of the edge score pipeline.
package ets_pkg;

	localparam int PROB_FRACTION_BITS = 16;
	localparam int PROB_W = PROB_FRACTION_BITS + 1;
	localparam int REG_W = 16;
	localparam int ADDR_W = 64;
	localparam int SIZE_W = 32;
	localparam int COUNT_W = 32;
	localparam int SCORE_W = 48;
	localparam int CFG_INDEX_W = 3;
	localparam int WP_W = REG_W + PROB_W;
	localparam int SUM_W = WP_W + COUNT_W;

	localparam logic [REG_W-1:0] FALL_WEIGHT_RST = 16'd4096;
	localparam logic [REG_W-1:0] FWD_WEIGHT_RST = 16'd410;
	localparam logic [REG_W-1:0] BWD_WEIGHT_RST = 16'd410;
	localparam logic [REG_W-1:0] FWD_LIMIT_RST = 16'd1024;
	localparam logic [REG_W-1:0] BWD_LIMIT_RST = 16'd640;

	typedef enum logic [1:0] {
		KIND_FALL = 2'd0,
		KIND_FWD = 2'd1,
		KIND_BWD = 2'd2,
		KIND_OUT = 2'd3
	} edge_kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FALL_WEIGHT = 3'd0,
		REG_FWD_WEIGHT = 3'd1,
		REG_BWD_WEIGHT = 3'd2,
		REG_FWD_LIMIT = 3'd3,
		REG_BWD_LIMIT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [REG_W-1:0] weight;
		edge_kind_t kind;
	} div_side_t;

endpackage

### design/ext_tsp_edge_score_core.sv
// Top level of the control-flow edge scorer with its configuration registers.
//
// Channel   Direction  Handshake                     Word
// s_axis    in         s_axis_tvalid/s_axis_tready   one edge
// m_axis    out        m_axis_tvalid/m_axis_tready   score and kind of one edge
// cfg       in         cfg_wr_en                     one register write
//
// One edge enters per cycle while the pipeline advances; the one-bit-per-stage divider
// forms the jump probability.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears the valid bits and loads the register defaults.
module ext_tsp_edge_score_core
	import ets_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// source_address [63:0], source_size [95:64], target_address [159:96], edge_count [191:160]
	input  logic [191:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// edge_score [47:0]
	output logic [SCORE_W-1:0] m_axis_tdata,
	// edge_kind [1:0]
	output logic [1:0] m_axis_tuser,
	input  logic cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_wdata
);

	logic [REG_W-1:0] fall_weight_q, fwd_weight_q, bwd_weight_q, fwd_limit_q, bwd_limit_q;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [ADDR_W:0] end_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic [COUNT_W-1:0] count_s1, count_s2, count_s3;
	logic [ADDR_W+1:0] diff_s2;
	logic [ADDR_W:0] dist_s3;
	logic fwd_s3, fall_s3;
	logic [REG_W-1:0] rem_s4, lim_s4;
	div_side_t side_s4;

	logic [ADDR_W+1:0] mag;
	logic [REG_W-1:0] lim_sel, weight_sel;
	logic in_range;
	edge_kind_t kind_sel;

	logic div_valid;
	logic [PROB_FRACTION_BITS-1:0] div_quot;
	div_side_t div_side;
	logic [PROB_W-1:0] prob;

	logic [WP_W-1:0] wp_s5;
	logic [COUNT_W-1:0] count_s5;
	edge_kind_t kind_s5, kind_s6, kind_s7;
	logic [COUNT_W+REG_W-1:0] plo_s6;
	logic [PROB_W+COUNT_W-1:0] phi_s6;
	logic [SUM_W-1:0] sum;
	logic [SCORE_W-1:0] score_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_weight_q <= FALL_WEIGHT_RST;
			fwd_weight_q <= FWD_WEIGHT_RST;
			bwd_weight_q <= BWD_WEIGHT_RST;
			fwd_limit_q <= FWD_LIMIT_RST;
			bwd_limit_q <= BWD_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FALL_WEIGHT: fall_weight_q <= cfg_wdata;
				REG_FWD_WEIGHT: fwd_weight_q <= cfg_wdata;
				REG_BWD_WEIGHT: bwd_weight_q <= cfg_wdata;
				REG_FWD_LIMIT: fwd_limit_q <= cfg_wdata;
				REG_BWD_LIMIT: bwd_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv = !v_s7 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= div_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign mag = diff_s2[ADDR_W+1] ? ((ADDR_W+2)'(0) - diff_s2) : diff_s2;

	always_comb begin
		lim_sel = fwd_s3 ? fwd_limit_q : bwd_limit_q;
		in_range = (dist_s3[ADDR_W:REG_W] == '0) && (dist_s3[REG_W-1:0] <= lim_sel)
			&& (lim_sel != '0);
		if (fall_s3) begin
			kind_sel = KIND_FALL;
			weight_sel = fall_weight_q;
		end else if (!in_range) begin
			kind_sel = KIND_OUT;
			weight_sel = '0;
		end else if (fwd_s3) begin
			kind_sel = KIND_FWD;
			weight_sel = fwd_weight_q;
		end else begin
			kind_sel = KIND_BWD;
			weight_sel = bwd_weight_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			end_s1 <= {1'b0, s_axis_tdata[63:0]} + (ADDR_W+1)'(s_axis_tdata[95:64]);
			dst_s1 <= s_axis_tdata[159:96];
			count_s1 <= s_axis_tdata[191:160];
			diff_s2 <= {1'b0, end_s1} - {2'b00, dst_s1};
			count_s2 <= count_s1;
			dist_s3 <= mag[ADDR_W:0];
			fwd_s3 <= diff_s2[ADDR_W+1];
			fall_s3 <= (diff_s2 == '0);
			count_s3 <= count_s2;
			rem_s4 <= (in_range && !fall_s3) ? (lim_sel - dist_s3[REG_W-1:0]) : '0;
			lim_s4 <= (in_range && !fall_s3) ? lim_sel : REG_W'(1);
			side_s4 <= '{count: count_s3, weight: weight_sel, kind: kind_sel};
		end
	end

	ets_prob_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s4),
		.in_rem(rem_s4),
		.in_lim(lim_s4),
		.in_side(side_s4),
		.out_valid(div_valid),
		.out_quot(div_quot),
		.out_side(div_side)
	);

	always_comb begin
		case (div_side.kind)
			KIND_FALL: prob = PROB_W'(1) << PROB_FRACTION_BITS;
			KIND_OUT: prob = '0;
			default: prob = {1'b0, div_quot};
		endcase
	end

	assign sum = {phi_s6, {REG_W{1'b0}}} + SUM_W'(plo_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			wp_s5 <= WP_W'(div_side.weight) * WP_W'(prob);
			count_s5 <= div_side.count;
			kind_s5 <= div_side.kind;
			plo_s6 <= (COUNT_W+REG_W)'(wp_s5[REG_W-1:0]) * (COUNT_W+REG_W)'(count_s5);
			phi_s6 <= (PROB_W+COUNT_W)'(wp_s5[WP_W-1:REG_W]) * (PROB_W+COUNT_W)'(count_s5);
			kind_s6 <= kind_s5;
			score_s7 <= sum[PROB_FRACTION_BITS +: SCORE_W];
			kind_s7 <= kind_s6;
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata = score_s7;
	assign m_axis_tuser = kind_s7;

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_OUT) |-> (m_axis_tdata == '0))
		else $error("out-of-range edge with nonzero score");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted word lost at pipeline entry");

	a_zero_fall_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_FALL && fall_weight_q == '0)
		|-> (m_axis_tdata == '0))
		else $error("fallthrough score nonzero with zero weight");

	a_stall_holds_div: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !m_axis_tready) |=> $stable(v_s5) && $stable(v_s6))
		else $error("pipeline moved during stall");

endmodule

### design/ets_prob_div.sv
// Pipelined fraction divider: one quotient bit per stage, floor(rem * 2^P / lim) for rem < lim.
module ets_prob_div
	import ets_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [REG_W-1:0] in_rem,
	input  logic [REG_W-1:0] in_lim,
	input  div_side_t in_side,
	output logic out_valid,
	output logic [PROB_FRACTION_BITS-1:0] out_quot,
	output div_side_t out_side
);

	logic valid_s [PROB_FRACTION_BITS];
	logic [REG_W-1:0] rem_s [PROB_FRACTION_BITS];
	logic [REG_W-1:0] lim_s [PROB_FRACTION_BITS];
	logic [PROB_FRACTION_BITS-1:0] quot_s [PROB_FRACTION_BITS];
	div_side_t side_s [PROB_FRACTION_BITS];

	for (genvar i = 0; i < PROB_FRACTION_BITS; i++) begin : g_stage
		logic valid_prev;
		logic [REG_W-1:0] rem_prev;
		logic [REG_W-1:0] lim_prev;
		logic [PROB_FRACTION_BITS-1:0] quot_prev;
		div_side_t side_prev;
		logic [REG_W:0] trial;
		logic [REG_W:0] diff;
		logic ge;

		if (i == 0) begin : g_first
			assign valid_prev = in_valid;
			assign rem_prev = in_rem;
			assign lim_prev = in_lim;
			assign quot_prev = '0;
			assign side_prev = in_side;
		end else begin : g_next
			assign valid_prev = valid_s[i-1];
			assign rem_prev = rem_s[i-1];
			assign lim_prev = lim_s[i-1];
			assign quot_prev = quot_s[i-1];
			assign side_prev = side_s[i-1];
		end

		assign trial = {rem_prev, 1'b0};
		assign diff = trial - {1'b0, lim_prev};
		assign ge = trial >= {1'b0, lim_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= valid_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
				lim_s[i] <= lim_prev;
				quot_s[i] <= {quot_prev[PROB_FRACTION_BITS-2:0], ge};
				side_s[i] <= side_prev;
			end
		end
	end

	assign out_valid = valid_s[PROB_FRACTION_BITS-1];
	assign out_quot = quot_s[PROB_FRACTION_BITS-1];
	assign out_side = side_s[PROB_FRACTION_BITS-1];

endmodule
